FILE: src/rc4_pkg.sv
// Shared constants and types for the RC4 stream cipher unit.
// No dependencies; imported by rc4_core and the top level.
`timescale 1ns / 1ps

package rc4_pkg;

    localparam int BYTE_W        = 8;
    localparam int SBOX_DEPTH    = 256;
    localparam int SBOX_AW       = 8;
    localparam int CFG_W         = 9;
    localparam int KEY_MAX_DEF   = 256;
    localparam int KEY_LEN_RESET = 16;

    typedef struct packed {
        logic               we;
        logic [SBOX_AW-1:0] waddr;
        logic [BYTE_W-1:0]  wdata;
        logic               re;
        logic [SBOX_AW-1:0] raddr;
    } sbox_req_t;

endpackage

FILE: src/rc4_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; used for the S-box and the key store.
`timescale 1ns / 1ps

module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/rc4_core.sv
// RC4 sequencer: key store fill, key schedule and keystream generation.
// Drives the S-box and key store memories; uses rc4_pkg.
`timescale 1ns / 1ps

module rc4_core #(
    parameter int KEY_MAX_BYTES = rc4_pkg::KEY_MAX_DEF,
    parameter int KAW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [rc4_pkg::CFG_W-1:0]   cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_func,
    input  logic [rc4_pkg::BYTE_W-1:0]  s_byte,
    output logic                        res_valid,
    output logic [rc4_pkg::BYTE_W-1:0]  res_byte,
    input  logic                        res_ready,
    output rc4_pkg::sbox_req_t          sbox_req,
    input  logic [rc4_pkg::BYTE_W-1:0]  sbox_rdata,
    output logic                        key_we,
    output logic [KAW-1:0]              key_waddr,
    output logic [rc4_pkg::BYTE_W-1:0]  key_wdata,
    output logic                        key_re,
    output logic [KAW-1:0]              key_raddr,
    input  logic [rc4_pkg::BYTE_W-1:0]  key_rdata
);

    import rc4_pkg::*;

    localparam int KCW = $clog2(KEY_MAX_BYTES + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_KS_J   = 4'd1;
    localparam logic [3:0] ST_KS_WI  = 4'd2;
    localparam logic [3:0] ST_KS_WJ  = 4'd3;
    localparam logic [3:0] ST_KS_OUT = 4'd4;
    localparam logic [3:0] ST_KSA_RD = 4'd5;
    localparam logic [3:0] ST_KSA_J  = 4'd6;
    localparam logic [3:0] ST_KSA_WK = 4'd7;
    localparam logic [3:0] ST_KSA_WJ = 4'd8;

    logic [3:0]         state_reg, state_next;
    logic [CFG_W-1:0]   key_len_reg;
    logic [KCW-1:0]     key_count_reg, key_count_next;
    logic [SBOX_AW-1:0] i_reg, i_next;
    logic [SBOX_AW-1:0] j_reg, j_next;
    logic [SBOX_AW-1:0] k_reg, k_next;
    logic [KAW-1:0]     kp_reg, kp_next;
    logic [BYTE_W-1:0]  byte_reg, byte_next;
    logic [BYTE_W-1:0]  si_reg, si_next;
    logic [BYTE_W-1:0]  sj_reg, sj_next;
    logic               hit_reg, hit_next;
    logic [SBOX_DEPTH-1:0] vld_reg;
    logic               vld_q_reg;
    logic [SBOX_AW-1:0] raddr_q_reg;
    logic               clr;

    logic [KCW-1:0]     eff_len;
    logic [KCW-1:0]     cnt_inc;
    logic [KCW-1:0]     kp_inc;
    logic [BYTE_W-1:0]  s_rd;
    logic [SBOX_AW-1:0] j_add;
    logic [SBOX_AW-1:0] ksa_j;
    logic [SBOX_AW-1:0] t_addr;

    // untouched entries read as their identity value
    assign s_rd = vld_q_reg ? sbox_rdata : raddr_q_reg;

    always_comb begin
        if (key_len_reg == '0) begin
            eff_len = KCW'(1);
        end else if (key_len_reg > CFG_W'(KEY_MAX_BYTES)) begin
            eff_len = KCW'(KEY_MAX_BYTES);
        end else begin
            eff_len = KCW'(key_len_reg);
        end
    end

    assign cnt_inc = key_count_reg + KCW'(1);
    assign kp_inc  = KCW'(kp_reg) + KCW'(1);
    assign j_add   = j_reg + s_rd;
    assign ksa_j   = j_reg + key_rdata + s_rd;
    assign t_addr  = si_reg + sj_reg;

    assign s_ready   = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_KS_OUT);
    assign res_byte  = byte_reg ^ (hit_reg ? si_reg : s_rd);

    always_comb begin
        state_next     = state_reg;
        key_count_next = key_count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        kp_next        = kp_reg;
        byte_next      = byte_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        hit_next       = hit_reg;
        clr            = 1'b0;
        sbox_req       = '0;
        key_we         = 1'b0;
        key_waddr      = key_count_reg[KAW-1:0];
        key_wdata      = s_byte;
        key_re         = 1'b0;
        key_raddr      = kp_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_func) begin
                        i_next         = i_reg + SBOX_AW'(1);
                        sbox_req.re    = 1'b1;
                        sbox_req.raddr = i_reg + SBOX_AW'(1);
                        byte_next      = s_byte;
                        state_next     = ST_KS_J;
                    end else begin
                        key_we = 1'b1;
                        if (cnt_inc >= eff_len) begin
                            key_count_next = '0;
                            clr            = 1'b1;
                            i_next         = '0;
                            j_next         = '0;
                            k_next         = '0;
                            kp_next        = '0;
                            state_next     = ST_KSA_RD;
                        end else begin
                            key_count_next = cnt_inc;
                        end
                    end
                end
            end
            ST_KS_J: begin
                si_next        = s_rd;
                j_next         = j_add;
                sbox_req.re    = 1'b1;
                sbox_req.raddr = j_add;
                state_next     = ST_KS_WI;
            end
            ST_KS_WI: begin
                sj_next        = s_rd;
                sbox_req.we    = 1'b1;
                sbox_req.waddr = i_reg;
                sbox_req.wdata = s_rd;
                state_next     = ST_KS_WJ;
            end
            ST_KS_WJ: begin
                // output entry equal to j is the one written now: forward it
                sbox_req.we    = 1'b1;
                sbox_req.waddr = j_reg;
                sbox_req.wdata = si_reg;
                sbox_req.re    = 1'b1;
                sbox_req.raddr = t_addr;
                hit_next       = (t_addr == j_reg);
                state_next     = ST_KS_OUT;
            end
            ST_KS_OUT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            ST_KSA_RD: begin
                sbox_req.re    = 1'b1;
                sbox_req.raddr = k_reg;
                key_re         = 1'b1;
                state_next     = ST_KSA_J;
            end
            ST_KSA_J: begin
                si_next        = s_rd;
                j_next         = ksa_j;
                sbox_req.re    = 1'b1;
                sbox_req.raddr = ksa_j;
                state_next     = ST_KSA_WK;
            end
            ST_KSA_WK: begin
                sbox_req.we    = 1'b1;
                sbox_req.waddr = k_reg;
                sbox_req.wdata = s_rd;
                state_next     = ST_KSA_WJ;
            end
            ST_KSA_WJ: begin
                sbox_req.we    = 1'b1;
                sbox_req.waddr = j_reg;
                sbox_req.wdata = si_reg;
                k_next         = k_reg + SBOX_AW'(1);
                kp_next        = (kp_inc >= eff_len) ? '0 : kp_inc[KAW-1:0];
                if (k_reg == SBOX_AW'(SBOX_DEPTH - 1)) begin
                    j_next     = '0;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_KSA_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            key_len_reg   <= CFG_W'(KEY_LEN_RESET);
            key_count_reg <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            kp_reg        <= '0;
            hit_reg       <= 1'b0;
            vld_q_reg     <= 1'b0;
            vld_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            key_count_reg <= key_count_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            kp_reg        <= kp_next;
            hit_reg       <= hit_next;
            if (cfg_wr_en) begin
                key_len_reg <= cfg_wr_data;
            end
            if (sbox_req.re) begin
                vld_q_reg <= vld_reg[sbox_req.raddr];
            end
            if (clr) begin
                vld_reg <= '0;
            end else if (sbox_req.we) begin
                vld_reg[sbox_req.waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        si_reg   <= si_next;
        sj_reg   <= sj_next;
        if (sbox_req.re) begin
            raddr_q_reg <= sbox_req.raddr;
        end
    end

endmodule

FILE: src/rc4_stream_cipher_unit.sv
// Top level of the RC4 stream cipher unit: memories, sequencer, output register.
// Depends on rc4_pkg, rc4_ram and rc4_core.
//
//  channel   dir  handshake              payload
//  s_        in   s_tvalid / s_tready    s_tdata = in_byte, s_tuser = func
//  m_        out  m_tvalid / m_tready    m_tdata = out_byte
//  cfg_      in   cfg_wr_en              cfg_wr_data = key_length
//
// A data request occupies the sequencer through states KS_J, KS_WI, KS_WJ and KS_OUT:
// its result goes from KS_OUT through the output register to m_tvalid, and the next
// request is taken back in idle, set by the read-swap-read sequence on the single
// S-box memory. A key request writes one key store byte; the one that completes a key
// adds the key schedule (256 swaps on the S-box), with s_tready low.
// Reset clears the S-box to identity at once through per-entry valid bits.
// A result waits in the output register; the next request is taken meanwhile,
// and the sequencer holds only when a new result meets a full register and m_tready is low.
`timescale 1ns / 1ps

module rc4_stream_cipher_unit #(
    parameter int KEY_MAX_BYTES = rc4_pkg::KEY_MAX_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [rc4_pkg::CFG_W-1:0]   cfg_wr_data,  // [8:0] key_length
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [rc4_pkg::BYTE_W-1:0]  s_tdata,      // [7:0] in_byte
    input  logic                        s_tuser,      // [0] func
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rc4_pkg::BYTE_W-1:0]  m_tdata       // [7:0] out_byte
);

    import rc4_pkg::*;

    localparam int KAW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;

    sbox_req_t         sbox_req;
    logic [BYTE_W-1:0] sbox_rdata;
    logic              key_we;
    logic [KAW-1:0]    key_waddr;
    logic [BYTE_W-1:0] key_wdata;
    logic              key_re;
    logic [KAW-1:0]    key_raddr;
    logic [BYTE_W-1:0] key_rdata;
    logic              res_valid;
    logic [BYTE_W-1:0] res_byte;
    logic              res_ready;
    logic              m_valid_reg;
    logic [BYTE_W-1:0] m_data_reg;

    rc4_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(SBOX_DEPTH),
        .AW   (SBOX_AW)
    ) u_sbox_ram (
        .aclk (aclk),
        .we   (sbox_req.we),
        .waddr(sbox_req.waddr),
        .wdata(sbox_req.wdata),
        .re   (sbox_req.re),
        .raddr(sbox_req.raddr),
        .rdata(sbox_rdata)
    );

    rc4_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(KEY_MAX_BYTES),
        .AW   (KAW)
    ) u_key_ram (
        .aclk (aclk),
        .we   (key_we),
        .waddr(key_waddr),
        .wdata(key_wdata),
        .re   (key_re),
        .raddr(key_raddr),
        .rdata(key_rdata)
    );

    rc4_core #(
        .KEY_MAX_BYTES(KEY_MAX_BYTES),
        .KAW          (KAW)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_func     (s_tuser),
        .s_byte     (s_tdata),
        .res_valid  (res_valid),
        .res_byte   (res_byte),
        .res_ready  (res_ready),
        .sbox_req   (sbox_req),
        .sbox_rdata (sbox_rdata),
        .key_we     (key_we),
        .key_waddr  (key_waddr),
        .key_wdata  (key_wdata),
        .key_re     (key_re),
        .key_raddr  (key_raddr),
        .key_rdata  (key_rdata)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= res_byte;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
